FILE: rtl/lrie_pkg.sv
// Package for the left-to-right integer expression core.
// Holds the token and operator codes, the controller state type and the command and status structs.
// No dependencies.
package lrie_pkg;

  localparam int unsigned DATA_W       = 32;
  localparam int unsigned IDX_W        = 9;
  localparam int unsigned IDX_MAX      = 511;
  localparam int unsigned MAX_TOKENS_D = 256;
  localparam int unsigned DIV_CNT_W    = $clog2(DATA_W);

  typedef enum logic [1:0] {
    KIND_START    = 2'd0,
    KIND_OPERATOR = 2'd1,
    KIND_INTEGER  = 2'd2,
    KIND_OTHER    = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_MOD = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_FIN
  } lrie_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;    // accept the input beat this cycle
    logic step;    // one quotient bit of the divider
    logic finish;  // write the divider result and load the output register
  } lrie_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_div;  // the waiting input beat starts a divide or modulo
    logic div_last;  // the divider is on its final bit
    logic out_free;  // the output register can take a beat this cycle
  } lrie_status_t;

endpackage

FILE: rtl/lrie_if.sv
// Channel interfaces of the left-to-right integer expression core.
// Depends on lrie_pkg for the data and index widths.
interface lrie_in_if import lrie_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [1:0]               kind;
  logic [2:0]               operator_code;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, kind, operator_code, value, input ready);
  modport sink   (input valid, kind, operator_code, value, output ready);
endinterface

interface lrie_out_if import lrie_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] accumulator_out;
  logic                     stopped;
  logic [IDX_W-1:0]         stop_position;
  logic                     skipped;
  logic                     divide_error;

  modport source (output valid, accumulator_out, stopped, stop_position, skipped,
                  divide_error, input ready);
  modport sink   (input valid, accumulator_out, stopped, stop_position, skipped,
                  divide_error, output ready);
endinterface

FILE: rtl/lrie_ctrl.sv
// Controller state machine of the left-to-right integer expression core.
// Depends on lrie_pkg; drives the datapath through lrie_cmd_t.
module lrie_ctrl import lrie_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  lrie_status_t status,
  output lrie_cmd_t    cmd,
  output lrie_state_t  state
);

  lrie_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && status.out_free && status.need_div) begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (status.div_last) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (status.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    cmd        = '0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = status.out_free;
        cmd.take = in_valid && status.out_free;
      end
      S_DIV: begin
        cmd.step = 1'b1;
      end
      S_FIN: begin
        cmd.finish = status.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assign state = state_r;

endmodule

FILE: rtl/lrie_dp.sv
// Datapath of the left-to-right integer expression core: evaluator state, adder,
// multiplier, a one-bit-per-cycle restoring divider and the output register.
// Depends on lrie_pkg; controlled by lrie_ctrl through lrie_cmd_t.
module lrie_dp import lrie_pkg::*; #(
  parameter int unsigned MAX_TOKENS = MAX_TOKENS_D
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  lrie_cmd_t                cmd,
  output lrie_status_t             status,
  input  logic [1:0]               in_kind,
  input  logic [2:0]               in_operator_code,
  input  logic signed [DATA_W-1:0] in_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [DATA_W-1:0]        out_accumulator,
  output logic                     out_stopped,
  output logic [IDX_W-1:0]         out_stop_position,
  output logic                     out_skipped,
  output logic                     out_divide_error
);

  localparam logic [IDX_W-1:0] IDX_CAP =
    IDX_W'((MAX_TOKENS > IDX_MAX) ? IDX_MAX : MAX_TOKENS);

  // Evaluator state.
  logic [DATA_W-1:0] acc_r, acc_nxt;
  logic              exp_op_r, exp_op_nxt;
  logic [2:0]        pend_r, pend_nxt;
  logic              halt_r, halt_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;

  // Divider state.
  logic [DATA_W-1:0]    rem_r, quo_r, dvs_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 q_neg_r, r_neg_r, is_mod_r;

  logic              out_valid_r;
  logic              skip, derr, need_div, live;
  logic [DATA_W-1:0] in_u, prod, acc_mag, val_mag, div_res;
  logic [DATA_W:0]   trial;
  logic [DATA_W-1:0] rem_sh;

  assign in_u    = DATA_W'(in_value);
  assign prod    = acc_r * in_u;
  assign acc_mag = acc_r[DATA_W-1] ? (~acc_r + 1'b1) : acc_r;
  assign val_mag = in_u[DATA_W-1] ? (~in_u + 1'b1) : in_u;
  assign live    = !halt_r && (idx_r < IDX_CAP);

  // Next evaluator state for the waiting input beat.
  always_comb begin
    acc_nxt    = acc_r;
    exp_op_nxt = exp_op_r;
    pend_nxt   = pend_r;
    halt_nxt   = halt_r;
    idx_nxt    = idx_r;
    skip       = 1'b0;
    derr       = 1'b0;
    need_div   = 1'b0;
    priority if (in_kind == KIND_START) begin
      acc_nxt    = in_u;
      exp_op_nxt = 1'b1;
      pend_nxt   = OP_ADD;
      halt_nxt   = 1'b0;
      idx_nxt    = '0;
    end else if (live && exp_op_r) begin
      if (in_kind == KIND_OPERATOR && in_operator_code <= OP_MOD) begin
        pend_nxt   = in_operator_code;
        exp_op_nxt = 1'b0;
        idx_nxt    = idx_r + 1'b1;
      end else begin
        halt_nxt = 1'b1;
      end
    end else if (live) begin
      idx_nxt = idx_r + 1'b1;
      if (in_kind == KIND_INTEGER) begin
        exp_op_nxt = 1'b1;
        unique case (pend_r)
          OP_ADD: acc_nxt = acc_r + in_u;
          OP_SUB: acc_nxt = acc_r - in_u;
          OP_MUL: acc_nxt = prod;
          OP_DIV, OP_MOD: begin
            if (in_u == '0) begin
              derr = 1'b1;
            end else begin
              need_div = 1'b1;
            end
          end
          default: acc_nxt = acc_r;
        endcase
      end else begin
        skip = 1'b1;
      end
    end else begin
      // Halted or at the token limit: the token changes nothing.
      acc_nxt = acc_r;
    end
  end

  // Restoring divider on magnitudes, one quotient bit per step.
  assign trial   = {rem_r, quo_r[DATA_W-1]} - {1'b0, dvs_r};
  assign rem_sh  = {rem_r[DATA_W-2:0], quo_r[DATA_W-1]};
  assign div_res = is_mod_r ? (r_neg_r ? (~rem_r + 1'b1) : rem_r)
                            : (q_neg_r ? (~quo_r + 1'b1) : quo_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      exp_op_r    <= 1'b1;
      pend_r      <= OP_ADD;
      halt_r      <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.take) begin
        exp_op_r <= exp_op_nxt;
        pend_r   <= pend_nxt;
        halt_r   <= halt_nxt;
        idx_r    <= idx_nxt;
        if (!need_div) begin
          acc_r <= acc_nxt;
        end
      end
      if (cmd.finish) begin
        acc_r <= div_res;
      end
      if ((cmd.take && !need_div) || cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && need_div) begin
      rem_r    <= '0;
      quo_r    <= acc_mag;
      dvs_r    <= val_mag;
      cnt_r    <= '0;
      q_neg_r  <= acc_r[DATA_W-1] ^ in_u[DATA_W-1];
      r_neg_r  <= acc_r[DATA_W-1];
      is_mod_r <= (pend_r == OP_MOD);
    end else if (cmd.step) begin
      cnt_r <= cnt_r + 1'b1;
      if (!trial[DATA_W]) begin
        rem_r <= trial[DATA_W-1:0];
        quo_r <= {quo_r[DATA_W-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh;
        quo_r <= {quo_r[DATA_W-2:0], 1'b0};
      end
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (cmd.take && !need_div) begin
      out_accumulator   <= acc_nxt;
      out_stopped       <= halt_nxt;
      out_stop_position <= idx_nxt;
      out_skipped       <= skip;
      out_divide_error  <= derr;
    end else if (cmd.finish) begin
      out_accumulator   <= div_res;
      out_stopped       <= halt_r;
      out_stop_position <= idx_r;
      out_skipped       <= 1'b0;
      out_divide_error  <= 1'b0;
    end
  end

  assign out_valid       = out_valid_r;
  assign status.need_div = need_div;
  assign status.div_last = (cnt_r == DIV_CNT_W'(DATA_W - 1));
  assign status.out_free = !out_valid_r || out_ready;

endmodule

FILE: rtl/left_to_right_integer_expression_core.sv
// Top level of the left-to-right integer expression core.
// Depends on lrie_pkg, lrie_if, lrie_ctrl and lrie_dp.
//
//   Channel   Direction  Carries
//   in_ch     sink       kind, operator_code, value (start, operator or operand token)
//   out_ch    source     accumulator_out, stopped, stop_position, skipped, divide_error
//
// Every accepted beat yields exactly one result beat. For start, operator, add, subtract,
// multiply, a divide or modulo by zero and all ignored tokens the result is registered at
// the edge that accepts the beat. A divide or modulo by a nonzero operand is accepted into
// the restoring divider, which resolves one quotient bit per cycle; then the sign is fixed
// and the result is loaded into the output register.
// Reset is synchronous and active low; it clears the evaluator to an accumulator of
// zero, waiting for an operator, pending add, not halted and token index zero.
// A new beat is taken while the previous result leaves in the same cycle; when the
// result is stalled the core holds in_ch.ready low, and a finished division waits.
module left_to_right_integer_expression_core import lrie_pkg::*; #(
  parameter int unsigned MAX_TOKENS = MAX_TOKENS_D
) (
  input  logic       clk,
  input  logic       rst_n,
  lrie_in_if.sink    in_ch,
  lrie_out_if.source out_ch
);

  localparam logic [IDX_W-1:0] TOP_CAP =
    IDX_W'((MAX_TOKENS > IDX_MAX) ? IDX_MAX : MAX_TOKENS);

  lrie_cmd_t    cmd;
  lrie_status_t status;
  lrie_state_t  state;
  logic [DATA_W-1:0] acc_out;

  // The controller sequences accepts, divider steps and the divider write-back.
  lrie_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd),
    .state    (state)
  );

  // The datapath holds all evaluator state and the output register.
  lrie_dp #(
    .MAX_TOKENS (MAX_TOKENS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .in_kind           (in_ch.kind),
    .in_operator_code  (in_ch.operator_code),
    .in_value          (in_ch.value),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_accumulator   (acc_out),
    .out_stopped       (out_ch.stopped),
    .out_stop_position (out_ch.stop_position),
    .out_skipped       (out_ch.skipped),
    .out_divide_error  (out_ch.divide_error)
  );

  assign out_ch.accumulator_out = acc_out;

  // A beat that needs the divider sends the controller into the divide loop.
  a_div_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && status.need_div) |=> (state == S_DIV))
    else $error("divide beat did not start the divider");

  // The divide loop runs until its final bit.
  a_div_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state == S_DIV && !status.div_last) |=> (state == S_DIV))
    else $error("divider left its loop early");

  // No input beat is taken while a division is under way.
  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state != S_IDLE) |-> !in_ch.ready)
    else $error("input accepted during division");

  // A halted result never also reports a skipped token or a zero divisor.
  a_stop_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.stopped) |-> (!out_ch.skipped && !out_ch.divide_error))
    else $error("halted result carries a token flag");

  // The reported position never passes the token limit.
  a_pos_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.stop_position <= TOP_CAP))
    else $error("stop position beyond token limit");

endmodule
